>>> design/smm_pkg.sv
// Shared constants, types and helpers for the small matrix multiply block.
// Used by the channel interfaces and every design module except smm_ram; no dependencies.
package smm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int MAX_ELEMS = 64;
  localparam int FRAC_BITS = 16;

  localparam int CFG_W  = 4;
  localparam int CIDX_W = 2;
  localparam int ROW_W  = 3;
  localparam int VAL_W  = 32;
  localparam int OP_W   = 2;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = $clog2(MAX_ELEMS);
  localparam int LD_W   = ROW_W + IDX_W + 1;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + IDX_W;

  localparam logic [ACC_W-1:0] RND_HALF =
      (FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;
  localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_ISSUE,
    ST_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } mac_tag_t;

  typedef struct packed {
    logic             load;
    logic             dim_error;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } out_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

endpackage

>>> design/smm_if.sv
// Valid/ready channel interfaces for the matrix multiply input and result streams.
// Depends on smm_pkg for field widths.
interface smm_in_if import smm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [ROW_W-1:0]        elem_row;
  logic [ROW_W-1:0]        elem_col;
  logic signed [VAL_W-1:0] elem_value;

  modport source (output valid, op, elem_row, elem_col, elem_value, input ready);
  modport sink (input valid, op, elem_row, elem_col, elem_value, output ready);
endinterface

interface smm_out_if import smm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [ROW_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    last;
  logic                    dim_error;

  modport source (output valid, out_row, out_col, out_value, last, dim_error, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, dim_error, output ready);
endinterface

>>> design/smm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/smm_mac.sv
// Shared multiply-accumulate unit: registered multiply, wide accumulate, round and saturate.
// Depends on smm_pkg for widths, tag type and rounding constants.
module smm_mac import smm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_tag_t                tag_i,
  input  logic signed [VAL_W-1:0] a_i,
  input  logic signed [VAL_W-1:0] b_i,
  output logic                    res_valid_o,
  output logic [VAL_W-1:0]        res_value_o
);

  mac_tag_t                 tag1_q, tag2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic                     done_q;
  logic [ACC_W-1:0]         rnd_q;
  logic                     rndv_q;
  logic signed [ACC_W-1:0]  shifted;
  logic                     in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      done_q <= 1'b0;
      rndv_q <= 1'b0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      done_q <= tag2_q.valid & tag2_q.lastk;
      rndv_q <= done_q;
    end
  end

  always_comb begin
    acc_d = (tag2_q.first ? '0 : acc_q) + ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i) begin
    if (tag1_q.valid) begin
      prod_q <= a_i * b_i;
    end
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
    if (done_q) begin
      rnd_q <= acc_q + RND_HALF;
    end
  end

  always_comb begin
    shifted  = $signed(rnd_q) >>> FRAC_BITS;
    in_range = (&shifted[ACC_W-1:VAL_W-1]) | ~(|shifted[ACC_W-1:VAL_W-1]);
    if (in_range) begin
      res_value_o = shifted[VAL_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res_value_o = SAT_MIN;
    end else begin
      res_value_o = SAT_MAX;
    end
  end

  assign res_valid_o = rndv_q;

endmodule

>>> design/smm_ctrl.sv
// Sequencer that walks rows, columns and the inner index of the product.
// Depends on smm_pkg for dimension clamping, states and control structs.
module smm_ctrl import smm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CFG_W-1:0]  a_rows_i,
  input  logic [CFG_W-1:0]  a_cols_i,
  input  logic [CFG_W-1:0]  b_rows_i,
  input  logic [CFG_W-1:0]  b_cols_i,
  input  logic              out_busy_i,
  input  logic              res_valid_i,
  output logic              idle_o,
  output logic [ADDR_W-1:0] rd_a_addr_o,
  output logic [ADDR_W-1:0] rd_b_addr_o,
  output mac_tag_t          tag_o,
  output out_ctl_t          out_ctl_o
);

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic             err_q, err_d;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic             lastk, last_j, last_elem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    ar        = clamp_dim(a_rows_i);
    ac        = clamp_dim(a_cols_i);
    br        = clamp_dim(b_rows_i);
    bc        = clamp_dim(b_cols_i);
    lastk     = (DIM_W'(k_q) == ac - DIM_W'(1));
    last_j    = (DIM_W'(j_q) == bc - DIM_W'(1));
    last_elem = last_j && (DIM_W'(i_q) == ar - DIM_W'(1));

    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    err_d   = err_q;
    tag_o   = '0;

    out_ctl_o           = '0;
    out_ctl_o.row       = ROW_W'(i_q);
    out_ctl_o.col       = ROW_W'(j_q);
    out_ctl_o.last      = last_elem;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          err_d   = (ac != br);
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_busy_i) begin
          if (err_q) begin
            out_ctl_o.load      = 1'b1;
            out_ctl_o.dim_error = 1'b1;
            out_ctl_o.last      = 1'b1;
            out_ctl_o.row       = '0;
            out_ctl_o.col       = '0;
            state_d             = ST_IDLE;
          end else begin
            k_d     = '0;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        tag_o.valid = 1'b1;
        tag_o.first = (k_q == '0);
        tag_o.lastk = lastk;
        k_d         = k_q + IDX_W'(1);
        if (lastk) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res_valid_i) begin
          out_ctl_o.load = 1'b1;
          if (last_elem) begin
            state_d = ST_IDLE;
          end else begin
            if (last_j) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
            state_d = ST_WAIT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign rd_a_addr_o = ADDR_W'(i_q * MAX_DIM + k_q);
  assign rd_b_addr_o = ADDR_W'(k_q * MAX_DIM + j_q);

endmodule

>>> design/small_matrix_multiply.sv
// Top level of the fixed-point matrix multiply: operand stores, sequencer, MAC, result register.
// Depends on smm_pkg, smm_if, smm_ram, smm_mac and smm_ctrl.
//
//   Channel  Direction  Contents
//   in_ch    sink       op, elem_row, elem_col, elem_value
//   out_ch   source     out_row, out_col, out_value, last, dim_error
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i (a_rows, a_cols, b_rows, b_cols)
//
// A load transaction writes the A or B store directly.
// A compute transaction uses one MAC; each result passes the registered store read, the multiply,
// accumulate and rounding stages before it is loaded into the output register.
// Each later element waits for the previous result to leave the output register before it is
// issued; a dimension mismatch loads a single error result without using the MAC.
// Reset clears control state only; the operand stores are undefined until loaded.
module small_matrix_multiply import smm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  smm_in_if.sink            in_ch,
  smm_out_if.source         out_ch,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  logic [CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  logic             in_acc, out_acc;
  logic             start, we_a, we_b, ld_ok;
  logic [LD_W-1:0]  load_idx;
  logic             idle;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  logic [VAL_W-1:0] rd_a_data, rd_b_data;
  mac_tag_t         tag;
  out_ctl_t         out_ctl;
  logic             res_valid;
  logic [VAL_W-1:0] res_value;

  logic             out_valid_q;
  logic [ROW_W-1:0] out_row_q, out_col_q;
  logic [VAL_W-1:0] out_value_q;
  logic             out_last_q, out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= CFG_W'(1);
      a_cols_q <= CFG_W'(1);
      b_rows_q <= CFG_W'(1);
      b_cols_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_ROWS: a_rows_q <= cfg_data_i;
        CFG_A_COLS: a_cols_q <= cfg_data_i;
        CFG_B_ROWS: b_rows_q <= cfg_data_i;
        CFG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign out_acc  = out_ch.valid & out_ch.ready;
  assign load_idx = LD_W'(in_ch.elem_row) * LD_W'(MAX_DIM) + LD_W'(in_ch.elem_col);
  assign ld_ok    = (32'(in_ch.elem_row) < MAX_DIM) && (32'(in_ch.elem_col) < MAX_DIM)
                    && (32'(load_idx) < MAX_ELEMS);

  always_comb begin
    start = 1'b0;
    we_a  = 1'b0;
    we_b  = 1'b0;
    unique case (in_ch.op)
      OP_LOAD_A:  we_a  = in_acc & ld_ok;
      OP_LOAD_B:  we_b  = in_acc & ld_ok;
      OP_COMPUTE: start = in_acc;
      default: ;
    endcase
  end

  smm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (ADDR_W'(load_idx)),
    .wdata_i (in_ch.elem_value),
    .re_i    (tag.valid),
    .raddr_i (rd_a_addr),
    .rdata_o (rd_a_data)
  );

  smm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (ADDR_W'(load_idx)),
    .wdata_i (in_ch.elem_value),
    .re_i    (tag.valid),
    .raddr_i (rd_b_addr),
    .rdata_o (rd_b_data)
  );

  smm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .a_rows_i    (a_rows_q),
    .a_cols_i    (a_cols_q),
    .b_rows_i    (b_rows_q),
    .b_cols_i    (b_cols_q),
    .out_busy_i  (out_valid_q),
    .res_valid_i (res_valid),
    .idle_o      (idle),
    .rd_a_addr_o (rd_a_addr),
    .rd_b_addr_o (rd_b_addr),
    .tag_o       (tag),
    .out_ctl_o   (out_ctl)
  );

  smm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .a_i         ($signed(rd_a_data)),
    .b_i         ($signed(rd_b_data)),
    .res_valid_o (res_valid),
    .res_value_o (res_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctl.load) begin
      out_row_q   <= out_ctl.row;
      out_col_q   <= out_ctl.col;
      out_value_q <= out_ctl.dim_error ? '0 : res_value;
      out_last_q  <= out_ctl.last;
      out_err_q   <= out_ctl.dim_error;
    end
  end

  assign in_ch.ready      = idle;
  assign out_ch.valid     = out_valid_q;
  assign out_ch.out_row   = out_row_q;
  assign out_ch.out_col   = out_col_q;
  assign out_ch.out_value = $signed(out_value_q);
  assign out_ch.last      = out_last_q;
  assign out_ch.dim_error = out_err_q;

  a_load_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ctl.load |-> !out_valid_q)
    else $error("Result register overwritten before its transaction completed.");

  a_result_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_ctl.load)
    else $error("MAC result arrived while the sequencer was not draining.");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> out_last_q)
    else $error("Dimension error result not marked last.");

  a_busy_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_ch.op == OP_COMPUTE) |=> !in_ch.ready)
    else $error("Input accepted again right after a compute command.");

endmodule
